@@ design/positional_ordered_list_defines.svh @@
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication.
`define POL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define POL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pol_pkg.sv @@
package pol_pkg;

  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Wide enough for any position (6 bits) and any count up to 64.
  localparam int CTRL_W      = 7;
  localparam int OUT_VALUE_W = 32;
  localparam int LEN_W       = 6;

  typedef enum logic [2:0] {
    K_APPEND   = 3'd0,
    K_INSERT   = 3'd1,
    K_DELETE   = 3'd2,
    K_READ_FWD = 3'd3,
    K_READ_BWD = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_EMPTY  = 2'd1,
    STS_FULL   = 2'd2,
    STS_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CO_HOLD    = 3'd0,
    CO_INSERT  = 3'd1,
    CO_DELETE  = 3'd2,
    CO_ROT_FWD = 3'd3,
    CO_ROT_BWD = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [CTRL_W-1:0] idx;
    logic [CTRL_W-1:0] cnt;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [OUT_VALUE_W-1:0] read_value;
    status_t                       status;
    logic                          end_of_run;
    logic [LEN_W-1:0]              list_length;
  } result_t;

endpackage

@@ design/pol_cell.sv @@
module pol_cell #(
  parameter int VALUE_WIDTH = pol_pkg::VALUE_WIDTH_DEF,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk,
  input  pol_pkg::cell_ctrl_t           ctrl,
  input  logic signed [VALUE_WIDTH-1:0] bcast_val,
  input  logic signed [VALUE_WIDTH-1:0] left_val,
  input  logic signed [VALUE_WIDTH-1:0] right_val,
  output logic signed [VALUE_WIDTH-1:0] val
);

  localparam logic [pol_pkg::CTRL_W-1:0] K   = pol_pkg::CTRL_W'(CELL_IDX);
  localparam logic [pol_pkg::CTRL_W-1:0] KP1 = pol_pkg::CTRL_W'(CELL_IDX + 1);

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic signed [VALUE_WIDTH-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      pol_pkg::CO_INSERT: begin
        if (K == ctrl.idx) begin
          val_nxt = bcast_val;
        end else if (K > ctrl.idx) begin
          val_nxt = left_val;
        end
      end
      pol_pkg::CO_DELETE: begin
        if (K >= ctrl.idx) begin
          val_nxt = right_val;
        end
      end
      // rotate the occupied span toward the front, head wraps to the tail slot
      pol_pkg::CO_ROT_FWD: begin
        if (KP1 == ctrl.cnt) begin
          val_nxt = bcast_val;
        end else if (K < ctrl.cnt) begin
          val_nxt = right_val;
        end
      end
      pol_pkg::CO_ROT_BWD: begin
        if (K == '0) begin
          val_nxt = bcast_val;
        end else if (K < ctrl.cnt) begin
          val_nxt = left_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

@@ design/pol_outq.sv @@
module pol_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pol_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output pol_pkg::result_t out_data
);

  pol_pkg::result_t q_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;
  logic             pop;

  assign out_valid = (fill_r != 2'd0);
  assign full      = (fill_r == 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

@@ design/positional_ordered_list.sv @@
// Bounded ordered list of signed words held in a chain of cells, one element
// per cell, each cell shifting to or from its neighbor.
// Input channel (in_valid/in_ready): one operation per transaction: append,
// positional insert, positional delete, forward or backward readout.
// Output channel (out_valid/out_ready): result transactions, end_of_run marks
// the last one of each operation.
// Append, insert and delete complete in the accept cycle and queue a status
// result, registered in the result queue; unknown kinds produce no result.
// A readout of N elements, N up to CAPACITY, occupies the chain after its
// accept, state_r entering ST_READ (one element per cycle while the result
// queue has room, each registered in the queue, the chain rotating by one
// each time) and returns it to its original order; in_ready is low meanwhile.
// A two-entry result queue separates the sides, so a new operation is taken
// while a result still waits; a stalled receiver fills the queue and then
// holds off readout steps and new operations. Nothing is dropped.
// Reset (rst_n low, synchronous) empties the list and the result queue; cell
// contents are not cleared and are never read beyond the current length.
`include "positional_ordered_list_defines.svh"

module positional_ordered_list #(
  parameter int CAPACITY    = pol_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = pol_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [2:0]                             in_kind,
  input  logic [5:0]                             in_position,
  input  logic signed [31:0]                     in_item_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pol_pkg::OUT_VALUE_W-1:0] out_read_value,
  output logic [1:0]                             out_status,
  output logic                                   out_end_of_run,
  output logic [pol_pkg::LEN_W-1:0]              out_list_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = pol_pkg::CTRL_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              dir_r, dir_nxt;   // 1: backward readout

  logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] bcast_val;
  logic signed [VALUE_WIDTH-1:0] item_vw;
  logic signed [VALUE_WIDTH-1:0] tail_val;
  logic signed [VALUE_WIDTH-1:0] read_sel;
  logic [IDX_W-1:0]              tail_idx;
  logic [CNT_W-1:0]              count_m1;

  pol_pkg::cell_ctrl_t ctrl;
  pol_pkg::result_t    push_res;
  pol_pkg::result_t    out_res;
  logic                push;
  logic                q_full;
  logic                in_fire;
  logic                read_push;
  logic [CW-1:0]       pos7, cnt7, cap7;

  assign in_ready  = (state_r == ST_IDLE) && !q_full;
  assign in_fire   = in_valid && in_ready;
  assign read_push = (state_r == ST_READ) && !q_full;

  assign item_vw  = VALUE_WIDTH'(in_item_value);
  assign count_m1 = count_r - 1'b1;
  assign tail_idx = count_m1[IDX_W-1:0];
  assign tail_val = cell_val[tail_idx];
  assign read_sel = dir_r ? tail_val : cell_val[0];

  assign pos7 = CW'(in_position);
  assign cnt7 = CW'(count_r);
  assign cap7 = CW'(CAPACITY);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    dir_nxt   = dir_r;
    ctrl.op   = pol_pkg::CO_HOLD;
    ctrl.idx  = '0;
    ctrl.cnt  = cnt7;
    bcast_val = item_vw;
    push      = 1'b0;
    push_res.read_value  = '0;
    push_res.status      = pol_pkg::STS_OK;
    push_res.end_of_run  = 1'b1;
    push_res.list_length = pol_pkg::LEN_W'(count_r);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            pol_pkg::K_APPEND: begin
              push = 1'b1;
              if (cnt7 == cap7) begin
                push_res.status = pol_pkg::STS_FULL;
              end else begin
                ctrl.op   = pol_pkg::CO_INSERT;
                ctrl.idx  = cnt7;
                count_nxt = count_r + 1'b1;
                push_res.list_length = pol_pkg::LEN_W'(count_r + 1'b1);
              end
            end
            pol_pkg::K_INSERT: begin
              push = 1'b1;
              if (count_r == '0) begin
                push_res.status = pol_pkg::STS_EMPTY;
              end else if (pos7 > cnt7) begin
                push_res.status = pol_pkg::STS_BADPOS;
              end else if (cnt7 == cap7) begin
                push_res.status = pol_pkg::STS_FULL;
              end else begin
                // positions 0 and 1 both land at the front
                ctrl.op   = pol_pkg::CO_INSERT;
                ctrl.idx  = (pos7 <= CW'(1)) ? '0 : pos7;
                count_nxt = count_r + 1'b1;
                push_res.list_length = pol_pkg::LEN_W'(count_r + 1'b1);
              end
            end
            pol_pkg::K_DELETE: begin
              push = 1'b1;
              if (count_r == '0) begin
                push_res.status = pol_pkg::STS_EMPTY;
              end else if (pos7 > cnt7) begin
                push_res.status = pol_pkg::STS_BADPOS;
              end else begin
                ctrl.op   = pol_pkg::CO_DELETE;
                ctrl.idx  = (pos7 <= CW'(1)) ? '0 : pos7 - CW'(1);
                count_nxt = count_m1;
                push_res.list_length = pol_pkg::LEN_W'(count_m1);
              end
            end
            pol_pkg::K_READ_FWD, pol_pkg::K_READ_BWD: begin
              if (count_r == '0) begin
                push = 1'b1;
                push_res.status = pol_pkg::STS_EMPTY;
              end else begin
                state_nxt = ST_READ;
                rem_nxt   = count_r;
                dir_nxt   = (in_kind == pol_pkg::K_READ_BWD);
              end
            end
            default: push = 1'b0;
          endcase
        end
      end
      ST_READ: begin
        if (read_push) begin
          push      = 1'b1;
          ctrl.op   = dir_r ? pol_pkg::CO_ROT_BWD : pol_pkg::CO_ROT_FWD;
          bcast_val = read_sel;
          push_res.read_value = pol_pkg::OUT_VALUE_W'(read_sel);
          push_res.end_of_run = (rem_r == CNT_W'(1));
          rem_nxt = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rem_r   <= '0;
      dir_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      dir_r   <= dir_nxt;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_v;
    logic signed [VALUE_WIDTH-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = bcast_val;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = bcast_val;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    pol_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CELL_IDX    (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bcast_val (bcast_val),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[g])
    );
  end

  pol_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_read_value  = out_res.read_value;
  assign out_status      = out_res.status;
  assign out_end_of_run  = out_res.end_of_run;
  assign out_list_length = out_res.list_length;

  `POL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "list count beyond capacity")
  `POL_ASSERT_NOW(a_busy_no_accept, state_r == ST_READ, !in_ready, "input taken during readout")
  `POL_ASSERT_NEXT(a_append_grows, in_fire && (in_kind == pol_pkg::K_APPEND) && (cnt7 != cap7), count_r == CNT_W'($past(count_r) + 1'b1), "append did not grow list")
  `POL_ASSERT_NEXT(a_read_done, read_push && (rem_r == CNT_W'(1)), state_r == ST_IDLE, "readout did not finish after last element")

endmodule

@@ sim/pol_list_check.sv @@
module pol_list_check
  import pol_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [2:0]                    in_kind,
  input  logic [5:0]                    in_position,
  input  logic signed [31:0]            in_item_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [OUT_VALUE_W-1:0] out_read_value,
  input  logic [1:0]                    out_status,
  input  logic                          out_end_of_run,
  input  logic [LEN_W-1:0]              out_list_length,
  output int                            mismatch_count,
  output int                            results_due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the list contents and length.
  logic signed [31:0] shadow_list [CAPACITY];
  int                 shadow_len;
  result_t            results_due [$];
  int                 mismatches;

  function automatic void post_status(status_t st);
    result_t r;
    r.read_value  = '0;
    r.status      = st;
    r.end_of_run  = 1'b1;
    r.list_length = LEN_W'(shadow_len);
    results_due.push_back(r);
  endfunction

  function automatic void insert_at(int idx, logic signed [31:0] val);
    for (int i = shadow_len; i > idx; i--)
      shadow_list[i] = shadow_list[i-1];
    shadow_list[idx] = val;
    shadow_len++;
  endfunction

  function automatic void apply_list_op(logic [2:0] kind, int pos, logic signed [31:0] val);
    result_t r;
    case (kind)
      K_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          post_status(STS_FULL);
        end else begin
          insert_at(shadow_len, val);
          post_status(STS_OK);
        end
      end
      K_INSERT: begin
        if (shadow_len == 0) begin
          post_status(STS_EMPTY);
        end else if (pos > shadow_len) begin
          post_status(STS_BADPOS);
        end else if (shadow_len >= CAPACITY) begin
          post_status(STS_FULL);
        end else begin
          // positions 0 and 1 go to the front, n >= 2 lands after element n
          insert_at((pos <= 1) ? 0 : pos, val);
          post_status(STS_OK);
        end
      end
      K_DELETE: begin
        if (shadow_len == 0) begin
          post_status(STS_EMPTY);
        end else if (pos > shadow_len) begin
          post_status(STS_BADPOS);
        end else begin
          for (int i = (pos <= 1) ? 0 : pos - 1; i + 1 < shadow_len; i++)
            shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          post_status(STS_OK);
        end
      end
      K_READ_FWD, K_READ_BWD: begin
        if (shadow_len == 0) begin
          post_status(STS_EMPTY);
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            r.read_value  = shadow_list[(kind == K_READ_FWD) ? i : shadow_len - 1 - i];
            r.status      = STS_OK;
            r.end_of_run  = (i + 1 == shadow_len);
            r.list_length = LEN_W'(shadow_len);
            results_due.push_back(r);
          end
        end
      end
      default: ;  // reserved kinds leave the list alone and produce nothing
    endcase
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    if (results_due.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result: value %0d status %0d last %0b length %0d",
                 $realtime, got.read_value, got.status, got.end_of_run, got.list_length);
      mismatches++;
    end else begin
      want = results_due.pop_front();
      if (got !== want) begin
        if (mismatches < 10)
          $display("%0t: result mismatch: expected value %0d status %0d last %0b length %0d, got value %0d status %0d last %0b length %0d",
                   $realtime, want.read_value, want.status, want.end_of_run,
                   want.list_length, got.read_value, got.status, got.end_of_run,
                   got.list_length);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_len = 0;
      results_due.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready)
        apply_list_op(in_kind, in_position, in_item_value);
      if (out_valid && out_ready)
        check_result({out_read_value, out_status, out_end_of_run, out_list_length});
    end
    mismatch_count    <= mismatches;
    results_due_count <= results_due.size();
  end

endmodule

@@ sim/tb_positional_ordered_list.sv @@
module tb_positional_ordered_list;
  timeunit 1ns;
  timeprecision 1ps;
  import pol_pkg::*;

  localparam int         STALL_LIMIT   = 2000;
  localparam int         SETTLE_CYCLES = CAPACITY_DEF + 8;
  localparam int         IDLE_PCT      = 25;
  localparam logic [2:0] KIND_RESERVED = 3'd5;  // first of the unused kind codes

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_ready;
  logic [2:0]                    in_kind       = K_APPEND;
  logic [5:0]                    in_position   = '0;
  logic signed [31:0]            in_item_value = '0;
  logic                          out_valid;
  logic                          out_ready     = 1'b0;
  logic signed [OUT_VALUE_W-1:0] out_read_value;
  logic [1:0]                    out_status;
  logic                          out_end_of_run;
  logic [LEN_W-1:0]              out_list_length;

  int mismatches;
  int results_due_count;
  int stall_cycles = 0;
  bit steady_flow  = 1'b0;

  positional_ordered_list dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_end_of_run (out_end_of_run),
    .out_list_length(out_list_length)
  );

  pol_list_check u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .out_end_of_run   (out_end_of_run),
    .out_list_length  (out_list_length),
    .mismatch_count   (mismatches),
    .results_due_count(results_due_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic issue_op(input logic [2:0] kind, input int pos, input logic signed [31:0] val);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_position   <= 6'(pos);
    in_item_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due_count != 0);
  endtask

  // Random operations; grow_pct/shrink_pct bias toward filling or draining.
  task automatic op_burst(input int count, input int grow_pct, input int shrink_pct);
    int                 done;
    int                 roll;
    int                 pos;
    logic [2:0]         kind;
    logic signed [31:0] val;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 3)
        kind = KIND_RESERVED + 3'($urandom_range(2));
      else if (roll < 3 + grow_pct)
        kind = ($urandom_range(9) < 6) ? K_APPEND : K_INSERT;
      else if (roll < 3 + grow_pct + shrink_pct)
        kind = K_DELETE;
      else
        kind = $urandom_range(1) ? K_READ_FWD : K_READ_BWD;
      roll = $urandom_range(9);
      if (roll < 6)
        pos = $urandom_range(20);
      else if (roll < 9)
        pos = $urandom_range(33);
      else
        pos = $urandom_range(63);
      case ($urandom_range(9))
        0:       val = 32'sh7fffffff;
        1:       val = 32'sh80000000;
        2:       val = $urandom_range(1) ? -32'sd1 : 32'sd0;
        default: val = $urandom;
      endcase
      issue_op(kind, pos, val);
      if (kind < KIND_RESERVED)
        done++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty-list cases, then removing the only element
    issue_op(K_READ_FWD, 0, 0);
    issue_op(K_INSERT, 1, 32'sd9);
    issue_op(K_DELETE, 1, 0);
    issue_op(K_APPEND, 0, 32'sh7fffffff);
    issue_op(K_DELETE, 1, 0);

    issue_op(K_APPEND, 0, 32'sh80000000);
    issue_op(K_APPEND, 0, 32'sh7fffffff);
    issue_op(K_APPEND, 0, -32'sd1);
    issue_op(K_APPEND, 0, 32'sd0);
    issue_op(K_INSERT, 0, 32'sh55555555);
    issue_op(K_INSERT, 1, 32'shAAAAAAAA);
    issue_op(K_INSERT, 2, 32'sd3);
    issue_op(K_INSERT, 7, -32'sd5);   // after the last element
    issue_op(K_INSERT, 9, 32'sd1);    // past the length
    issue_op(K_INSERT, 63, 32'sd1);
    issue_op(K_READ_FWD, 0, 0);
    issue_op(K_READ_BWD, 0, 0);
    issue_op(K_DELETE, 63, 0);
    issue_op(K_DELETE, 9, 0);
    issue_op(K_DELETE, 0, 0);
    issue_op(K_DELETE, 7, 0);
    issue_op(KIND_RESERVED, 1, 32'sd1);
    issue_op(KIND_RESERVED + 3'd1, 2, 32'sd2);
    issue_op(KIND_RESERVED + 3'd2, 3, 32'sd3);
    issue_op(K_READ_BWD, 0, 0);

    op_burst(45, 78, 7);
    await_results();
    op_burst(40, 8, 70);
    steady_flow <= 1'b1;
    op_burst(20, 40, 35);
    steady_flow <= 1'b0;
    op_burst(15, 40, 35);

    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
